[rtl/core/billboard_particle_axis_expand_assert.svh]
// Assertion macros for the billboard particle axis expander.
// Included by the RTL files that check their own logic; needs clk_i and rst_ni in scope.
`ifndef BILLBOARD_PARTICLE_AXIS_EXPAND_ASSERT_SVH
`define BILLBOARD_PARTICLE_AXIS_EXPAND_ASSERT_SVH
`ifndef SYNTHESIS
`define BPAE_ASSERT_HOLD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BPAE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define BPAE_ASSERT_HOLD(lbl, prop, msg)
`define BPAE_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[rtl/core/bpae_pkg.sv]
// Shared types, constants and helper functions of the billboard particle axis expander.
// No dependencies; imported by bpae_norm, billboard_particle_axis_expand and the testbench.
`default_nettype none
package bpae_pkg;

  localparam logic [2:0]         NumCfg      = 3'd6;
  localparam logic [18:0]        TwoPiQ16    = 19'd411775;
  localparam logic signed [20:0] TwoPiS      = 21'sd411775;
  localparam logic signed [20:0] PiQ16       = 21'sd205887;
  localparam logic signed [20:0] HalfPiQ16   = 21'sd102944;
  // 2^31 mod 2pi in Q16.16: undoes the offset that makes the angle unsigned
  localparam logic signed [20:0] AngOffset   = 21'sd77023;
  localparam logic signed [33:0] CordicGain  = 34'sd652032874;
  localparam logic [31:0]        TagHi       = 32'h50415254;
  localparam logic [63:0]        MinSqLen    = 64'd42;
  localparam logic [17:0]        UnitQ16     = 18'd65536;
  localparam logic [31:0]        RecipK      = 32'((64'd1 << 50) / 64'd411775);

  typedef struct packed {
    logic [2:0][17:0] rt;
    logic [2:0][17:0] up;
  } unit_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      5'd24: v = 34'sd64;
      5'd25: v = 34'sd32;
      5'd26: v = 34'sd16;
      5'd27: v = 34'sd8;
      5'd28: v = 34'sd4;
      5'd29: v = 34'sd2;
      5'd30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/bpae_norm.sv]
// Camera vector registers and their serial normalizer (squares, square root, divide).
// Depends on bpae_pkg.
`default_nettype none
module bpae_norm (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [2:0]     cfg_idx_i,
  input  wire logic [31:0]    cfg_data_i,
  output logic                busy_o,
  output bpae_pkg::unit_t     unit_o
);
  import bpae_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSq   = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StRoot = 3'd3;
  localparam logic [2:0] StLoad = 3'd4;
  localparam logic [2:0] StDiv  = 3'd5;

  logic [2:0]  st_q;
  logic        vec_q;
  logic [1:0]  comp_q;
  logic [5:0]  cnt_q;
  logic [63:0] acc_q;
  logic [63:0] res_q;
  logic [63:0] sbit_q;
  logic [31:0] rem_q;
  logic [47:0] dvd_q;
  logic [31:0] cam_q [6];
  unit_t       unit_q;

  logic [2:0]  sel;
  logic [31:0] cam_sel;
  logic [31:0] mag;
  logic [63:0] sq;
  logic [63:0] rb;
  logic [32:0] t;
  logic        ge;
  logic [16:0] quo;
  logic [17:0] uval;

  assign sel     = vec_q ? 3'(comp_q) + 3'd3 : 3'(comp_q);
  assign cam_sel = cam_q[sel];
  assign mag     = cam_sel[31] ? 32'(-cam_sel) : cam_sel;
  assign sq      = {32'd0, mag} * {32'd0, mag};
  assign rb      = res_q + sbit_q;
  assign t       = {rem_q, dvd_q[47]};
  assign ge      = t >= {1'b0, res_q[31:0]};
  assign quo     = {dvd_q[15:0], ge};
  assign uval    = cam_sel[31] ? 18'(-{1'b0, quo}) : {1'b0, quo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      vec_q     <= 1'b0;
      comp_q    <= 2'd0;
      cnt_q     <= 6'd0;
      cam_q[0]  <= 32'd65536;
      cam_q[1]  <= 32'd0;
      cam_q[2]  <= 32'd0;
      cam_q[3]  <= 32'd0;
      cam_q[4]  <= 32'd65536;
      cam_q[5]  <= 32'd0;
      unit_q.rt <= {18'd0, 18'd0, UnitQ16};
      unit_q.up <= {18'd0, UnitQ16, 18'd0};
    end else if (cfg_we_i && cfg_idx_i < NumCfg) begin
      // restart the whole pass on any register write
      cam_q[cfg_idx_i] <= cfg_data_i;
      st_q   <= StSq;
      vec_q  <= 1'b0;
      comp_q <= 2'd0;
    end else begin
      case (st_q)
        StSq: begin
          if (comp_q == 2'd2) begin
            comp_q <= 2'd0;
            st_q   <= StChk;
          end else begin
            comp_q <= comp_q + 2'd1;
          end
        end
        StChk: begin
          cnt_q <= 6'd0;
          if (acc_q <= MinSqLen) begin
            // short vector: use the fallback axis
            if (vec_q) begin
              unit_q.up <= {18'd0, UnitQ16, 18'd0};
              st_q      <= StIdle;
            end else begin
              unit_q.rt <= {18'd0, 18'd0, UnitQ16};
              vec_q     <= 1'b1;
              st_q      <= StSq;
            end
          end else begin
            st_q <= StRoot;
          end
        end
        StRoot: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) begin
            st_q <= StLoad;
          end
        end
        StLoad: begin
          cnt_q <= 6'd0;
          st_q  <= StDiv;
        end
        StDiv: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd47) begin
            if (vec_q) begin
              unit_q.up[comp_q] <= uval;
            end else begin
              unit_q.rt[comp_q] <= uval;
            end
            if (comp_q == 2'd2) begin
              comp_q <= 2'd0;
              if (vec_q) begin
                st_q <= StIdle;
              end else begin
                vec_q <= 1'b1;
                st_q  <= StSq;
              end
            end else begin
              comp_q <= comp_q + 2'd1;
              st_q   <= StLoad;
            end
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cfg_we_i && cfg_idx_i < NumCfg) begin
      acc_q <= 64'd0;
    end else begin
      case (st_q)
        StSq: acc_q <= acc_q + sq;
        StChk: begin
          acc_q  <= (acc_q <= MinSqLen) ? 64'd0 : acc_q;
          res_q  <= 64'd0;
          sbit_q <= 64'd1 << 62;
        end
        StRoot: begin
          if (acc_q >= rb) begin
            acc_q <= acc_q - rb;
            res_q <= (res_q >> 1) + sbit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
        end
        StLoad: begin
          rem_q <= 32'd0;
          dvd_q <= {mag, 16'd0};
        end
        StDiv: begin
          rem_q <= ge ? 32'(t - {1'b0, res_q[31:0]}) : t[31:0];
          dvd_q <= {dvd_q[46:0], ge};
          if (cnt_q == 6'd47 && comp_q == 2'd2) begin
            acc_q <= 64'd0;
          end
        end
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign busy_o = st_q != StIdle;
  assign unit_o = unit_q;

endmodule
`default_nettype wire

[rtl/core/billboard_particle_axis_expand.sv]
// Billboard particle axis expander: one particle in, one set of billboard axes out.
// Rate: one particle per clock once the camera vectors are normalized and the output
// is not stalled. Stages: capture, angle reduction, one per CORDIC step, direction
// products, direction sums, magnitude product, saturating output register. A camera
// register write starts a serial normalizer (squares, 32-step square root, 48-step
// division per component) that holds in_ready_o low from the write cycle until done.
// Depends on bpae_pkg, bpae_norm and billboard_particle_axis_expand_assert.svh.
`default_nettype none
`include "billboard_particle_axis_expand_assert.svh"
module billboard_particle_axis_expand #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] pos_z_i,
  input  wire logic [30:0] particle_size_i,
  input  wire logic [31:0] rotation_angle_i,
  input  wire logic [31:0] scale_x_i,
  input  wire logic [31:0] scale_y_i,
  input  wire logic [63:0] color_in_i,
  input  wire logic [31:0] batch_id_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      axis_right_x_o,
  output logic [31:0]      axis_right_y_o,
  output logic [31:0]      axis_right_z_o,
  output logic [31:0]      axis_up_x_o,
  output logic [31:0]      axis_up_y_o,
  output logic [31:0]      axis_up_z_o,
  output logic [31:0]      out_pos_x_o,
  output logic [31:0]      out_pos_y_o,
  output logic [31:0]      out_pos_z_o,
  output logic [63:0]      color_out_o,
  output logic [63:0]      object_id_o
);
  import bpae_pkg::*;

  // Stages: 0 capture, 1 reciprocal and magnitude multiplies, 2 remainder,
  // 3 quadrant fold, then one per CORDIC step, then P1 direction products,
  // P2 direction sums, P3 magnitude product, P4 saturate (output register).
  localparam int unsigned CS = CORDIC_STEPS;
  localparam int unsigned N  = CS + 8;
  localparam int unsigned P1 = CS + 4;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [63:0] color;
    logic [31:0] batch;
    logic [31:0] msx;
    logic [31:0] msy;
    logic        flip;
  } side_t;

  logic        norm_busy;
  unit_t       unit;
  logic        accept;

  logic [N-1:0] vld_q;
  logic [N:0]   en;
  side_t        side_q  [N];
  side_t        side_in [N];

  bpae_norm u_norm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (norm_busy),
    .unit_o     (unit)
  );

  // A stage advances when it is empty or its successor advances: bubbles collapse,
  // so the input keeps flowing while the output register waits, until the bubbles are filled.
  always_comb begin
    en[N] = out_ready_i;
    for (int k = int'(N) - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  // Hold off requests on a stalled entry, during a register write and while the normalizer rewrites the unit vectors.
  assign in_ready_o = en[0] && !norm_busy && !cfg_we_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= accept;
      end
      for (int k = 1; k < int'(N); k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---- stage 0: capture ----
  logic [31:0] ang0_q, sx0_q, sy0_q;
  logic [30:0] size0_q;
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ang0_q  <= rotation_angle_i;
      size0_q <= particle_size_i;
      sx0_q   <= scale_x_i;
      sy0_q   <= scale_y_i;
    end
  end

  // ---- stage 1: angle offset to unsigned, reciprocal multiply, size * scale ----
  logic [31:0]        u0;
  logic [31:0]        u1_q;
  logic [63:0]        prodk1_q;
  logic signed [63:0] mx1_q, my1_q;
  assign u0 = {~ang0_q[31], ang0_q[30:0]};
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      u1_q     <= u0;
      prodk1_q <= {32'd0, u0} * {32'd0, RecipK};
      mx1_q    <= $signed({33'd0, size0_q}) * $signed({{32{sx0_q[31]}}, sx0_q});
      my1_q    <= $signed({33'd0, size0_q}) * $signed({{32{sy0_q[31]}}, sy0_q});
    end
  end

  // ---- stage 2: remainder estimate, below twice 2pi ----
  logic [13:0] qe;
  logic [32:0] qm;
  logic [32:0] rem_full;
  logic [19:0] rem2_q;
  assign qe       = prodk1_q[63:50];
  assign qm       = 33'(qe) * 33'(TwoPiQ16);
  assign rem_full = {1'b0, u1_q} - qm;
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      rem2_q <= rem_full[19:0];
    end
  end

  // ---- stage 3: finish modulo, fold into [-pi/2, pi/2] ----
  logic signed [20:0] r1;
  logic [18:0]        r0;
  logic               flip3;
  logic signed [33:0] z3;
  always_comb begin
    r0    = (rem2_q >= 20'(TwoPiQ16)) ? 19'(rem2_q - 20'(TwoPiQ16)) : rem2_q[18:0];
    r1    = $signed({2'b00, r0}) - AngOffset;
    flip3 = 1'b0;
    if (r1 < 0) begin
      r1 = r1 + TwoPiS;
    end
    if (r1 > PiQ16) begin
      r1 = r1 - TwoPiS;
    end
    if (r1 > HalfPiQ16) begin
      r1    = r1 - PiQ16;
      flip3 = 1'b1;
    end else if (r1 < -HalfPiQ16) begin
      r1    = r1 + PiQ16;
      flip3 = 1'b1;
    end
    z3 = $signed({{13{r1[20]}}, r1}) <<< 14;
  end

  logic signed [33:0] cx_q [CS+1];
  logic signed [33:0] cy_q [CS+1];
  logic signed [33:0] cz_q [CS+1];
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      cx_q[0] <= CordicGain;
      cy_q[0] <= 34'sd0;
      cz_q[0] <= z3;
    end
  end

  // ---- CORDIC: one rotation step per stage ----
  for (genvar i = 0; i < int'(CS); i++) begin : g_cordic
    logic signed [33:0] dx, dy, at;
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;
    assign at = atan_q30(5'(i));
    always_ff @(posedge clk_i) begin
      if (en[4+i]) begin
        if (!cz_q[i][33]) begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          cz_q[i+1] <= cz_q[i] - at;
        end else begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          cz_q[i+1] <= cz_q[i] + at;
        end
      end
    end
  end

  // ---- P1: direction products ----
  logic signed [34:0] cc, ss;
  assign cc = side_q[P1-1].flip ? -$signed({cx_q[CS][33], cx_q[CS]})
                                :  $signed({cx_q[CS][33], cx_q[CS]});
  assign ss = side_q[P1-1].flip ? -$signed({cy_q[CS][33], cy_q[CS]})
                                :  $signed({cy_q[CS][33], cy_q[CS]});

  logic signed [52:0] prc_q [3];
  logic signed [52:0] pus_q [3];
  logic signed [52:0] puc_q [3];
  logic signed [52:0] prs_q [3];
  logic signed [23:0] dr_q  [3];
  logic signed [23:0] du_q  [3];
  logic signed [55:0] axr_q [3];
  logic signed [55:0] axu_q [3];
  logic [31:0]        ar_q  [3];
  logic [31:0]        au_q  [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [17:0] rti, upi;
    logic signed [53:0] sr, su;
    logic signed [63:0] er, eu;
    assign rti = $signed(unit.rt[i]);
    assign upi = $signed(unit.up[i]);
    assign sr  = $signed({prc_q[i][52], prc_q[i]}) + $signed({pus_q[i][52], pus_q[i]});
    assign su  = $signed({puc_q[i][52], puc_q[i]}) - $signed({prs_q[i][52], prs_q[i]});
    assign er  = $signed({{8{axr_q[i][55]}}, axr_q[i]}) >>> 16;
    assign eu  = $signed({{8{axu_q[i][55]}}, axu_q[i]}) >>> 16;

    always_ff @(posedge clk_i) begin
      if (en[P1]) begin
        prc_q[i] <= rti * cc;
        pus_q[i] <= upi * ss;
        puc_q[i] <= upi * cc;
        prs_q[i] <= rti * ss;
      end
      // P2: floor shift by 30 back to Q16.16
      if (en[P1+1]) begin
        dr_q[i] <= sr[53:30];
        du_q[i] <= su[53:30];
      end
      // P3: scale by the saturated magnitudes
      if (en[P1+2]) begin
        axr_q[i] <= dr_q[i] * $signed(side_q[P1+1].msx);
        axu_q[i] <= du_q[i] * $signed(side_q[P1+1].msy);
      end
      // P4: saturate into the output register
      if (en[P1+3]) begin
        ar_q[i] <= sat32(er);
        au_q[i] <= sat32(eu);
      end
    end
  end

  // ---- sideband payload that rides along with each request ----
  always_comb begin
    side_in[0].pos_x = pos_x_i;
    side_in[0].pos_y = pos_y_i;
    side_in[0].pos_z = pos_z_i;
    side_in[0].color = color_in_i;
    side_in[0].batch = batch_id_i;
    side_in[0].msx   = '0;
    side_in[0].msy   = '0;
    side_in[0].flip  = 1'b0;
    for (int k = 1; k < int'(N); k++) begin
      side_in[k] = side_q[k-1];
    end
    side_in[2].msx  = sat32(mx1_q >>> 16);
    side_in[2].msy  = sat32(my1_q >>> 16);
    side_in[3].flip = flip3;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < int'(N); k++) begin
      if (en[k]) begin
        side_q[k] <= side_in[k];
      end
    end
  end

  assign out_valid_o    = vld_q[N-1];
  assign axis_right_x_o = ar_q[0];
  assign axis_right_y_o = ar_q[1];
  assign axis_right_z_o = ar_q[2];
  assign axis_up_x_o    = au_q[0];
  assign axis_up_y_o    = au_q[1];
  assign axis_up_z_o    = au_q[2];
  assign out_pos_x_o    = side_q[N-1].pos_x;
  assign out_pos_y_o    = side_q[N-1].pos_y;
  assign out_pos_z_o    = side_q[N-1].pos_z;
  assign color_out_o    = side_q[N-1].color;
  assign object_id_o    = {TagHi, side_q[N-1].batch};

  `BPAE_ASSERT_HOLD(a_no_accept_busy, !(accept && norm_busy), "request taken during normalization")
  `BPAE_ASSERT_NEXT(a_accept_fills, accept, vld_q[0], "accepted request lost at entry")
  `BPAE_ASSERT_NEXT(a_cfg_starts_norm, cfg_we_i && (cfg_idx_i < NumCfg), norm_busy && !in_ready_o, "register write did not start normalization")

endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for billboard_particle_axis_expand: drives particle requests and
// camera register writes, predicts every result and compares it field by field.
// Depends on bpae_pkg and the RTL of billboard_particle_axis_expand.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import bpae_pkg::*;

  localparam int unsigned STEPS   = 16;
  localparam int unsigned LATENCY = STEPS + 8;
  localparam longint      LIMIT   = 400000;

  // camera register indexes
  localparam logic [2:0] REG_RIGHT_X = 3'd0;
  localparam logic [2:0] REG_RIGHT_Y = 3'd1;
  localparam logic [2:0] REG_RIGHT_Z = 3'd2;
  localparam logic [2:0] REG_UP_X    = 3'd3;
  localparam logic [2:0] REG_UP_Y    = 3'd4;
  localparam logic [2:0] REG_UP_Z    = 3'd5;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  localparam longint TWO_PI  = 411775;
  localparam longint PI      = 205887;
  localparam longint HALF_PI = 102944;
  localparam longint UNIT    = 65536;
  localparam longint GAIN    = 652032874;
  localparam longint SAT_MAX = 64'sd2147483647;
  localparam longint SAT_MIN = -64'sd2147483648;
  localparam logic [31:0] TAG = 32'h50415254;

  localparam longint ATAN_TBL [32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0};

  typedef struct packed {
    logic [31:0] pos_x, pos_y, pos_z;
    logic [30:0] size;
    logic [31:0] angle, scale_x, scale_y;
    logic [63:0] color;
    logic [31:0] batch;
  } particle_t;

  // result fields in port order, each zero-extended to 64 bits
  typedef logic [10:0][63:0] billboard_t;

  localparam string FIELD_NAME [11] = '{"axis_right_x", "axis_right_y", "axis_right_z",
    "axis_up_x", "axis_up_y", "axis_up_z", "out_pos_x", "out_pos_y", "out_pos_z",
    "color_out", "object_id"};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  particle_t   req = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] axis_right_x_o, axis_right_y_o, axis_right_z_o;
  logic [31:0] axis_up_x_o, axis_up_y_o, axis_up_z_o;
  logic [31:0] out_pos_x_o, out_pos_y_o, out_pos_z_o;
  logic [63:0] color_out_o, object_id_o;

  billboard_particle_axis_expand #(.CORDIC_STEPS(STEPS)) DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .pos_x_i(req.pos_x), .pos_y_i(req.pos_y), .pos_z_i(req.pos_z),
    .particle_size_i(req.size), .rotation_angle_i(req.angle),
    .scale_x_i(req.scale_x), .scale_y_i(req.scale_y),
    .color_in_i(req.color), .batch_id_i(req.batch),
    .out_valid_o, .out_ready_i,
    .axis_right_x_o, .axis_right_y_o, .axis_right_z_o,
    .axis_up_x_o, .axis_up_y_o, .axis_up_z_o,
    .out_pos_x_o, .out_pos_y_o, .out_pos_z_o, .color_out_o, .object_id_o);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor copy of the camera registers, sign-extended
  longint     cam_vec [6];
  billboard_t pending_billboards [$];
  int         mismatches = 0;
  bit         idling_on = 1'b1;
  longint     cycles = 0;

  // Run watchdog: end the run when the limit is reached.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint clamp32(longint v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < SAT_MIN) return SAT_MIN;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  // Normalize one camera vector; short vectors fall back to the given unit axis.
  function automatic void unit_axis(input int base, input int axis, output longint u [3]);
    longint unsigned sq = 0;
    longint unsigned len;
    longint q;
    for (int i = 0; i < 3; i++) sq += abs64(cam_vec[base + i]) * abs64(cam_vec[base + i]);
    if (sq <= 64'd42) begin
      for (int i = 0; i < 3; i++) u[i] = (i == axis) ? UNIT : 0;
      return;
    end
    len = root_floor(sq);
    for (int i = 0; i < 3; i++) begin
      q = longint'((abs64(cam_vec[base + i]) << 16) / len);
      u[i] = cam_vec[base + i] < 0 ? -q : q;
    end
  endfunction

  // Reduce the angle to a half turn around zero, fold it into [-pi/2, pi/2], then rotate the gain vector.
  function automatic void rotation_sincos(input longint ang, output longint c, output longint s);
    longint r = ang % TWO_PI;
    longint x = GAIN, y = 0, z, dx, dy;
    bit flip = 1'b0;
    if (r < 0) r += TWO_PI;
    if (r > PI) r -= TWO_PI;
    if (r > HALF_PI) begin
      r -= PI;
      flip = 1'b1;
    end else if (r < -HALF_PI) begin
      r += PI;
      flip = 1'b1;
    end
    z = r * 16384;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic billboard_t expand_billboard(particle_t p);
    billboard_t b;
    longint rt [3];
    longint up [3];
    longint c, s, msx, msy, dr, du, sz, v;
    unit_axis(0, 0, rt);
    unit_axis(3, 1, up);
    rotation_sincos(longint'(signed'(p.angle)), c, s);
    sz  = longint'({1'b0, p.size});
    msx = clamp32((sz * longint'(signed'(p.scale_x))) >>> 16);
    msy = clamp32((sz * longint'(signed'(p.scale_y))) >>> 16);
    for (int i = 0; i < 3; i++) begin
      dr = (rt[i] * c + up[i] * s) >>> 30;
      du = (up[i] * c - rt[i] * s) >>> 30;
      v = clamp32((dr * msx) >>> 16);
      b[i] = {32'd0, v[31:0]};
      v = clamp32((du * msy) >>> 16);
      b[3 + i] = {32'd0, v[31:0]};
    end
    b[6]  = {32'd0, p.pos_x};
    b[7]  = {32'd0, p.pos_y};
    b[8]  = {32'd0, p.pos_z};
    b[9]  = p.color;
    b[10] = {TAG, p.batch};
    return b;
  endfunction

  // Result side: randomly drop ready before each result while idling is on, compare on each handshake.
  initial begin
    int n;
    forever begin
      n = idling_on ? $urandom_range(0, 5) : 0;
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    billboard_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {color_out_o, object_id_o, 32'd0, out_pos_z_o, 32'd0, out_pos_y_o,
             32'd0, out_pos_x_o, 32'd0, axis_up_z_o, 32'd0, axis_up_y_o,
             32'd0, axis_up_x_o, 32'd0, axis_right_z_o, 32'd0, axis_right_y_o,
             32'd0, axis_right_x_o};
      // packed order above puts color_out at the top; fix the two 64-bit fields
      got[10] = object_id_o;
      got[9]  = color_out_o;
      if (pending_billboards.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        want = pending_billboards.pop_front();
        for (int f = 0; f < 11; f++) begin
          if (got[f] !== want[f]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%s mismatch: expected %h, got %h", FIELD_NAME[f], want[f], got[f]);
          end
        end
      end
    end
  end

  // Send one particle request: optional gap, then hold valid until accepted.
  task automatic send_particle(particle_t p);
    int gap;
    gap = idling_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req        <= p;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_billboards.insert(pending_billboards.size(), expand_billboard(p));
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every result has come back, plus pipeline latency.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_billboards.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic write_camera(logic [2:0] idx, logic [31:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= REG_UP_Z) cam_vec[idx] = longint'(signed'(data));
  endtask

  task automatic load_camera(logic [31:0] rx, ry, rz, ux, uy, uz);
    write_camera(REG_RIGHT_X, rx);
    write_camera(REG_RIGHT_Y, ry);
    write_camera(REG_RIGHT_Z, rz);
    write_camera(REG_UP_X, ux);
    write_camera(REG_UP_Y, uy);
    write_camera(REG_UP_Z, uz);
  endtask

  function automatic particle_t random_particle(bit wide);
    particle_t p;
    p.pos_x   = $urandom;
    p.pos_y   = $urandom;
    p.pos_z   = $urandom;
    p.color   = {$urandom, $urandom};
    p.batch   = $urandom;
    if (wide || $urandom_range(0, 9) == 0) begin
      p.size    = 31'($urandom);
      p.angle   = $urandom;
      p.scale_x = $urandom;
      p.scale_y = $urandom;
    end else begin
      // typical particles: a few units in size, unit-ish scale, angle within a turn either way
      p.size    = 31'($urandom_range(0, 32'h0008_0000));
      p.angle   = $urandom_range(0, 32'h000C_0000) - 32'h0006_0000;
      p.scale_x = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      p.scale_y = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    end
    return p;
  endfunction

  // Extremes of every field and the angle quadrant boundaries at reset camera.
  task automatic test_directed_extremes;
    particle_t p;
    longint angles [12] = '{0, HALF_PI, HALF_PI + 1, -HALF_PI, -HALF_PI - 1, PI, -PI,
                           PI + 1, TWO_PI, -TWO_PI, SAT_MAX, SAT_MIN};
    foreach (angles[k]) begin
      p = '{pos_x: 32'h7fffffff, pos_y: 32'h80000000, pos_z: 32'h0, size: 31'h10000,
            angle: angles[k][31:0], scale_x: 32'h10000, scale_y: 32'h10000,
            color: 64'hffff_ffff_ffff_ffff, batch: 32'h1};
      send_particle(p);
    end
    // saturating magnitudes and zero-size particles
    p = '{32'h0, 32'h1, 32'hffffffff, 31'h7fffffff, 32'h0, 32'h7fffffff, 32'h80000000,
          64'h0, 32'h0};
    send_particle(p);
    p = '{32'h0, 32'h1, 32'hffffffff, 31'h7fffffff, 32'h0001_0000, 32'h80000000,
          32'h7fffffff, 64'h0123_4567_89ab_cdef, 32'hffffffff};
    send_particle(p);
    p = '{32'h0, 32'h0, 32'h0, 31'h0, 32'h0, 32'h7fffffff, 32'h7fffffff,
          64'h0, 32'h0};
    send_particle(p);
    p = '{32'h0, 32'h0, 32'h0, 31'h7fffffff, 32'h0, 32'h0, 32'h0, 64'h0, 32'h0};
    send_particle(p);
  endtask

  // Short camera vectors select the fallback axes; the boundary sits at 42 vs 43.
  task automatic test_camera_fallback;
    particle_t p;
    load_camera(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    for (int i = 0; i < 3; i++) send_particle(random_particle(1'b0));
    load_camera(32'd6, 32'd2, 32'd1, -32'sd6, 32'd2, -32'sd1);  // squared length 41
    for (int i = 0; i < 3; i++) send_particle(random_particle(1'b0));
    load_camera(32'd6, 32'd2, -32'sd1, 32'd5, 32'd3, 32'd3);    // squared lengths 41 and 43
    for (int i = 0; i < 3; i++) send_particle(random_particle(1'b0));
    // longest possible right vector, near-longest up vector
    load_camera(32'h80000000, 32'h80000000, 32'h80000000,
                32'h7fffffff, 32'h80000000, 32'h7fffffff);
    p = random_particle(1'b1);
    send_particle(p);
  endtask

  // Writes beyond the register list leave the camera untouched.
  task automatic test_spare_index;
    write_camera(REG_SPARE_A, $urandom);
    write_camera(REG_SPARE_B, $urandom);
    for (int i = 0; i < 4; i++) send_particle(random_particle(1'b0));
  endtask

  task automatic test_random_stream;
    logic [31:0] c [6];
    for (int phase = 0; phase < 8; phase++) begin
      for (int j = 0; j < 6; j++) begin
        case (phase % 4)
          0: c[j] = $urandom;
          1: c[j] = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
          2: c[j] = $urandom_range(0, 16) - 8;
          default: c[j] = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        endcase
      end
      load_camera(c[0], c[1], c[2], c[3], c[4], c[5]);
      // alternate stretches with and without idling on both sides
      idling_on = (phase % 3) != 2;
      for (int i = 0; i < 200; i++) begin
        send_particle(random_particle(phase == 5));
        // hold off once until the pipeline is fully empty
        if (phase == 1 && i == 100) drain();
      end
    end
    idling_on = 1'b1;
  endtask

  initial begin
    cam_vec = '{UNIT, 0, 0, 0, UNIT, 0};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_extremes();
    test_camera_fallback();
    test_spare_index();
    test_random_stream();
    drain();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
